// ===== rtl/msw_pkg.sv =====
`timescale 1ns / 1ps
package msw_pkg;

    // Box coordinates while the search runs; the box never leaves a few hundred pixels.
    localparam int CRD_W     = 10;
    // Pixel offset from the box centre.
    localparam int OFF_W     = 12;
    // Weight times offset.
    localparam int PRD_W     = 21;
    // Moment sums: up to 255 x 255 cells, weight 255, offset 255.
    localparam int MOM_W     = 34;
    localparam int WS_W      = 24;
    // Rounded shift numerator 2*M + W and denominator 2*W.
    localparam int DIV_NW    = MOM_W + 2;
    localparam int DIV_DW    = WS_W + 1;
    // Shift of one mean-shift step.
    localparam int SHF_W     = 10;
    localparam int OUT_W     = 9;
    localparam int SHO_W     = 7;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 8;

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_RUN  = 1'b1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_IMAGE_WIDTH  = 2'd0,
        CFG_IMAGE_HEIGHT = 2'd1,
        CFG_SHIFT_LIMIT  = 2'd2,
        CFG_MAX_ITER     = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic signed [CRD_W-1:0] left;
        logic signed [CRD_W-1:0] top;
        logic signed [CRD_W-1:0] right;
        logic signed [CRD_W-1:0] bottom;
    } t_box;

    typedef struct packed {
        logic                    start;
        t_box                    box;
        logic signed [CRD_W-1:0] cx;
        logic signed [CRD_W-1:0] cy;
    } t_gather_req;

    typedef struct packed {
        logic                    done;
        logic signed [MOM_W-1:0] mx;
        logic signed [MOM_W-1:0] my;
        logic [WS_W-1:0]         ws;
    } t_gather_rsp;

    // Midpoint of coordinates a and b, truncated toward zero.
    function automatic logic signed [CRD_W-1:0] mid(input logic signed [CRD_W-1:0] a,
                                                   input logic signed [CRD_W-1:0] b);
        logic signed [CRD_W:0] s;
        logic signed [CRD_W:0] q;
        s = (CRD_W+1)'(a) + (CRD_W+1)'(b);
        q = (s + (CRD_W+1)'(s[CRD_W])) >>> 1;
        return q[CRD_W-1:0];
    endfunction

endpackage

// ===== rtl/msw_if.sv =====
`timescale 1ns / 1ps
interface msw_in_if;
    logic       valid;
    logic       ready;
    logic       operation;
    logic [6:0] pixel_x;
    logic [6:0] pixel_y;
    logic [7:0] weight;
    logic [7:0] box_left;
    logic [7:0] box_top;
    logic [7:0] box_right;
    logic [7:0] box_bottom;

    modport source (output valid, operation, pixel_x, pixel_y, weight,
                    box_left, box_top, box_right, box_bottom, input ready);
    modport sink   (input valid, operation, pixel_x, pixel_y, weight,
                    box_left, box_top, box_right, box_bottom, output ready);
endinterface

interface msw_res_if;
    logic              valid;
    logic              ready;
    logic signed [8:0] out_left;
    logic signed [8:0] out_top;
    logic signed [8:0] out_right;
    logic signed [8:0] out_bottom;
    logic signed [6:0] shift_x;
    logic signed [6:0] shift_y;
    logic [3:0]        steps_used;
    logic              empty_window;

    modport source (output valid, out_left, out_top, out_right, out_bottom,
                    shift_x, shift_y, steps_used, empty_window, input ready);
    modport sink   (input valid, out_left, out_top, out_right, out_bottom,
                    shift_x, shift_y, steps_used, empty_window, output ready);
endinterface

interface msw_cfg_if;
    logic       valid;
    logic       ready;
    logic [1:0] index;
    logic [7:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/msw_ram.sv =====
`timescale 1ns / 1ps
module msw_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16384,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic             i_rd_en,
    input  logic [AW-1:0]    i_rd_addr,
    output logic [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== rtl/msw_div.sv =====
`timescale 1ns / 1ps
module msw_div #(
    parameter int NW   = 36,
    parameter int DW   = 25,
    parameter int QW   = 10,
    localparam int CNTW = $clog2(NW)
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic signed [NW-1:0] i_num,
    input  logic [DW-1:0]        i_den,
    output logic                 o_done,
    output logic signed [QW-1:0] o_quot
);

    logic            r_busy;
    logic            r_done;
    logic [CNTW-1:0] r_cnt;
    logic            r_neg;
    logic [NW-1:0]   r_mag;
    logic [DW-1:0]   r_rem;
    logic [DW-1:0]   r_den;
    logic [DW:0]     trial;
    logic            fits;
    logic [NW-1:0]   quot;

    // Restoring division, one quotient bit per cycle; the dividend shifts out
    // of r_mag as the quotient shifts in.
    assign trial = {r_rem, r_mag[NW-1]};
    assign fits  = trial >= {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNTW'(NW - 1);
                r_neg  <= i_num[NW-1];
                r_mag  <= i_num[NW-1] ? NW'(-i_num) : NW'(i_num);
                r_rem  <= '0;
                r_den  <= i_den;
            end else if (r_busy) begin
                r_mag <= {r_mag[NW-2:0], fits};
                r_rem <= fits ? DW'(trial - {1'b0, r_den}) : trial[DW-1:0];
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt - 1'b1;
                end
            end
        end
    end

    // Floor division: a negative quotient with a remainder steps one further down.
    always_comb begin
        if (!r_neg) begin
            quot = r_mag;
        end else if (r_rem != '0) begin
            quot = ~r_mag;
        end else begin
            quot = NW'(-r_mag);
        end
    end

    assign o_done = r_done;
    assign o_quot = quot[QW-1:0];

endmodule

// ===== rtl/msw_gather.sv =====
`timescale 1ns / 1ps
module msw_gather #(
    parameter int IMG_W = 128,
    parameter int IMG_H = 128,
    localparam int AW   = $clog2(IMG_W * IMG_H)
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  msw_pkg::t_gather_req i_req,
    output msw_pkg::t_gather_rsp o_rsp,
    output logic                 o_rd_en,
    output logic [AW-1:0]        o_rd_addr,
    input  logic [7:0]           i_rd_data
);
    import msw_pkg::*;

    localparam int XW = $clog2(IMG_W);
    localparam int YW = $clog2(IMG_H);
    localparam int EW = 12;
    localparam logic signed [EW-1:0] LIM_X = EW'(IMG_W);
    localparam logic signed [EW-1:0] LIM_Y = EW'(IMG_H);

    function automatic logic signed [EW-1:0] clip(input logic signed [EW-1:0] v,
                                                 input logic signed [EW-1:0] hi);
        logic signed [EW-1:0] r;
        r = v;
        if (v < 0) begin
            r = '0;
        end else if (v > hi) begin
            r = hi;
        end
        return r;
    endfunction

    logic signed [EW-1:0]    c0, c1, r0, r1, c_last, r_last;
    logic                    none;
    logic signed [OFF_W-1:0] off_x, off_y;

    logic                    r_active;
    logic                    r_busy;
    logic                    r_done;
    logic [XW-1:0]           r_col, r_col_lo, r_col_last;
    logic [YW-1:0]           r_row, r_row_last;
    logic signed [CRD_W-1:0] r_cx, r_cy;
    logic                    r_b_valid;
    logic signed [OFF_W-1:0] r_b_offx, r_b_offy;
    logic                    r_c_valid;
    logic signed [PRD_W-1:0] r_c_px, r_c_py;
    logic [7:0]              r_c_w;
    logic signed [MOM_W-1:0] r_mx, r_my;
    logic [WS_W-1:0]         r_ws;

    // Cells outside the frame weigh nothing, so the scan covers the box
    // clipped to the frame only.
    always_comb begin
        c0     = clip(EW'(i_req.box.left), LIM_X);
        c1     = clip(EW'(i_req.box.right), LIM_X);
        r0     = clip(EW'(i_req.box.top), LIM_Y);
        r1     = clip(EW'(i_req.box.bottom), LIM_Y);
        c_last = c1 - EW'(1);
        r_last = r1 - EW'(1);
        none   = (c0 >= c1) || (r0 >= r1);
    end

    assign off_x     = OFF_W'(r_col) - OFF_W'(r_cx);
    assign off_y     = OFF_W'(r_row) - OFF_W'(r_cy);
    assign o_rd_en   = r_busy;
    assign o_rd_addr = AW'(r_row) * AW'(IMG_W) + AW'(r_col);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active  <= 1'b0;
            r_busy    <= 1'b0;
            r_done    <= 1'b0;
            r_b_valid <= 1'b0;
            r_c_valid <= 1'b0;
        end else begin
            r_done    <= 1'b0;
            r_b_valid <= r_busy;
            r_c_valid <= r_b_valid;
            if (i_req.start) begin
                r_active   <= 1'b1;
                r_busy     <= !none;
                r_col      <= c0[XW-1:0];
                r_col_lo   <= c0[XW-1:0];
                r_col_last <= c_last[XW-1:0];
                r_row      <= r0[YW-1:0];
                r_row_last <= r_last[YW-1:0];
                r_cx       <= i_req.cx;
                r_cy       <= i_req.cy;
                r_mx       <= '0;
                r_my       <= '0;
                r_ws       <= '0;
            end else begin
                if (r_busy) begin
                    if (r_col == r_col_last) begin
                        r_col <= r_col_lo;
                        if (r_row == r_row_last) begin
                            r_busy <= 1'b0;
                        end else begin
                            r_row <= r_row + 1'b1;
                        end
                    end else begin
                        r_col <= r_col + 1'b1;
                    end
                end
                if (r_c_valid) begin
                    r_mx <= r_mx + MOM_W'(r_c_px);
                    r_my <= r_my + MOM_W'(r_c_py);
                    r_ws <= r_ws + WS_W'(r_c_w);
                end
                if (r_active && !r_busy && !r_b_valid && !r_c_valid) begin
                    r_active <= 1'b0;
                    r_done   <= 1'b1;
                end
            end
        end
    end

    // Offsets travel alongside the read so they line up with the returned weight.
    always_ff @(posedge i_clk) begin
        r_b_offx <= off_x;
        r_b_offy <= off_y;
        r_c_px   <= $signed({1'b0, i_rd_data}) * r_b_offx;
        r_c_py   <= $signed({1'b0, i_rd_data}) * r_b_offy;
        r_c_w    <= i_rd_data;
    end

    assign o_rsp.done = r_done;
    assign o_rsp.mx   = r_mx;
    assign o_rsp.my   = r_my;
    assign o_rsp.ws   = r_ws;

endmodule

// ===== rtl/mean_shift_window_centroid.sv =====
// Load words write one weight pixel each and are taken back to back.
// For a run word, each step scans the clipped box one frame-memory read per
// cycle, then one shared divider works out the shift on each axis in turn.
// No input is taken while a search runs.
// Reset is synchronous; it restores the register defaults and clears control
// state. The frame memory is not cleared and holds garbage until loaded.
`timescale 1ns / 1ps
module mean_shift_window_centroid #(
    parameter int IMG_W = 128,
    parameter int IMG_H = 128
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    msw_in_if.sink    i_in,
    msw_res_if.source o_res,
    msw_cfg_if.sink   i_cfg
);
    import msw_pkg::*;

    localparam int AW = $clog2(IMG_W * IMG_H);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_G_START,
        ST_G_WAIT,
        ST_DX_START,
        ST_DX_WAIT,
        ST_DY_START,
        ST_DY_WAIT,
        ST_MOVE,
        ST_FINISH
    } t_state;

    t_state                  r_state;
    logic [7:0]              r_img_w, r_img_h;
    logic [5:0]              r_lim;
    logic [3:0]              r_max_it;
    t_box                    r_box;
    logic signed [CRD_W-1:0] r_cx, r_cy, r_cx0, r_cy0;
    logic [7:0]              r_bl, r_bt, r_br, r_bb;
    logic [3:0]              r_steps;
    logic                    r_empty;
    logic signed [SHF_W-1:0] r_dx, r_dy;
    logic                    r_out_valid;
    logic signed [OUT_W-1:0] r_out_left, r_out_top, r_out_right, r_out_bottom;
    logic signed [SHO_W-1:0] r_shift_x, r_shift_y;
    logic [3:0]              r_out_steps;
    logic                    r_out_empty;

    logic                    in_acc;
    logic                    wr_en;
    logic [AW-1:0]           wr_addr;
    logic                    rd_en;
    logic [AW-1:0]           rd_addr;
    logic [7:0]              rd_data;
    t_gather_req             g_req;
    t_gather_rsp             g_rsp;
    logic                    div_start;
    logic signed [DIV_NW-1:0] div_num;
    logic [DIV_DW-1:0]       div_den;
    logic                    div_done;
    logic signed [SHF_W-1:0] div_quot;
    logic signed [MOM_W-1:0] div_mom;

    logic signed [CRD_W:0]   sum_l, sum_r, sum_t, sum_b, w_lim, h_lim;
    logic signed [CRD_W-1:0] n_left, n_right, n_top, n_bottom, n_cx, n_cy;
    logic signed [CRD_W:0]   off_x, off_y, lim;
    logic signed [SHO_W-1:0] n_shift_x, n_shift_y;
    logic                    out_free;
    logic                    more;

    assign in_acc      = i_in.valid && i_in.ready;
    assign i_in.ready  = (r_state == ST_IDLE);
    assign i_cfg.ready = 1'b1;
    assign out_free    = !r_out_valid || o_res.ready;

    // Loads outside the frame are dropped.
    assign wr_en   = in_acc && (i_in.operation == OP_LOAD)
                     && (32'(i_in.pixel_x) < 32'(IMG_W)) && (32'(i_in.pixel_y) < 32'(IMG_H));
    assign wr_addr = AW'(i_in.pixel_y) * AW'(IMG_W) + AW'(i_in.pixel_x);

    msw_ram #(
        .WIDTH (8),
        .DEPTH (IMG_W * IMG_H)
    ) u_frame (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (i_in.weight),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    assign g_req.start = (r_state == ST_G_START);
    assign g_req.box   = r_box;
    assign g_req.cx    = r_cx;
    assign g_req.cy    = r_cy;

    msw_gather #(
        .IMG_W (IMG_W),
        .IMG_H (IMG_H)
    ) u_gather (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (g_req),
        .o_rsp     (g_rsp),
        .o_rd_en   (rd_en),
        .o_rd_addr (rd_addr),
        .i_rd_data (rd_data)
    );

    // Round half up: floor((2*M + W) / (2*W)).
    assign div_start = (r_state == ST_DX_START) || (r_state == ST_DY_START);
    assign div_mom   = (r_state == ST_DY_START) ? g_rsp.my : g_rsp.mx;
    assign div_num   = (DIV_NW'(div_mom) <<< 1) + DIV_NW'(g_rsp.ws);
    assign div_den   = {g_rsp.ws, 1'b0};

    msw_div #(
        .NW (DIV_NW),
        .DW (DIV_DW),
        .QW (SHF_W)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    // Box move after one step, clamped to the image.
    always_comb begin
        sum_l    = (CRD_W+1)'(r_box.left) + (CRD_W+1)'(r_dx);
        sum_r    = (CRD_W+1)'(r_box.right) + (CRD_W+1)'(r_dx);
        sum_t    = (CRD_W+1)'(r_box.top) + (CRD_W+1)'(r_dy);
        sum_b    = (CRD_W+1)'(r_box.bottom) + (CRD_W+1)'(r_dy);
        w_lim    = $signed((CRD_W+1)'(r_img_w));
        h_lim    = $signed((CRD_W+1)'(r_img_h));
        n_left   = (sum_l < 0) ? '0 : sum_l[CRD_W-1:0];
        n_top    = (sum_t < 0) ? '0 : sum_t[CRD_W-1:0];
        n_right  = (sum_r > w_lim) ? w_lim[CRD_W-1:0] : sum_r[CRD_W-1:0];
        n_bottom = (sum_b > h_lim) ? h_lim[CRD_W-1:0] : sum_b[CRD_W-1:0];
        n_cx     = mid(n_left, n_right);
        n_cy     = mid(n_top, n_bottom);
        more     = ((r_dx != '0) || (r_dy != '0)) && (r_steps < r_max_it);
    end

    // Final offset of the centre, limited per axis.
    always_comb begin
        off_x = (CRD_W+1)'(r_cx) - (CRD_W+1)'(r_cx0);
        off_y = (CRD_W+1)'(r_cy) - (CRD_W+1)'(r_cy0);
        lim   = $signed((CRD_W+1)'(r_lim));
        if (off_x > lim) begin
            off_x = lim;
        end else if (off_x < -lim) begin
            off_x = -lim;
        end
        if (off_y > lim) begin
            off_y = lim;
        end else if (off_y < -lim) begin
            off_y = -lim;
        end
        n_shift_x = off_x[SHO_W-1:0];
        n_shift_y = off_y[SHO_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_img_w  <= 8'd128;
            r_img_h  <= 8'd128;
            r_lim    <= 6'd15;
            r_max_it <= 4'd10;
        end else if (i_cfg.valid && i_cfg.ready) begin
            case (t_cfg_idx'(i_cfg.index))
                CFG_IMAGE_WIDTH:  r_img_w  <= i_cfg.data;
                CFG_IMAGE_HEIGHT: r_img_h  <= i_cfg.data;
                CFG_SHIFT_LIMIT:  r_lim    <= i_cfg.data[5:0];
                CFG_MAX_ITER:     r_max_it <= i_cfg.data[3:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
            r_steps     <= '0;
            r_empty     <= 1'b0;
        end else begin
            if (r_out_valid && o_res.ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (in_acc && (i_in.operation == OP_RUN)) begin
                        r_bl         <= i_in.box_left;
                        r_bt         <= i_in.box_top;
                        r_br         <= i_in.box_right;
                        r_bb         <= i_in.box_bottom;
                        r_box.left   <= CRD_W'(i_in.box_left);
                        r_box.top    <= CRD_W'(i_in.box_top);
                        r_box.right  <= CRD_W'(i_in.box_right);
                        r_box.bottom <= CRD_W'(i_in.box_bottom);
                        r_cx0 <= mid(CRD_W'(i_in.box_left), CRD_W'(i_in.box_right));
                        r_cy0 <= mid(CRD_W'(i_in.box_top), CRD_W'(i_in.box_bottom));
                        r_cx  <= mid(CRD_W'(i_in.box_left), CRD_W'(i_in.box_right));
                        r_cy  <= mid(CRD_W'(i_in.box_top), CRD_W'(i_in.box_bottom));
                        r_steps <= '0;
                        r_empty <= 1'b0;
                        r_state <= (r_max_it == '0) ? ST_FINISH : ST_G_START;
                    end
                end
                ST_G_START: begin
                    r_state <= ST_G_WAIT;
                end
                ST_G_WAIT: begin
                    if (g_rsp.done) begin
                        r_steps <= r_steps + 1'b1;
                        if (g_rsp.ws == '0) begin
                            r_empty <= 1'b1;
                            r_state <= ST_FINISH;
                        end else begin
                            r_state <= ST_DX_START;
                        end
                    end
                end
                ST_DX_START: begin
                    r_state <= ST_DX_WAIT;
                end
                ST_DX_WAIT: begin
                    if (div_done) begin
                        r_dx    <= div_quot;
                        r_state <= ST_DY_START;
                    end
                end
                ST_DY_START: begin
                    r_state <= ST_DY_WAIT;
                end
                ST_DY_WAIT: begin
                    if (div_done) begin
                        r_dy    <= div_quot;
                        r_state <= ST_MOVE;
                    end
                end
                ST_MOVE: begin
                    r_box.left   <= n_left;
                    r_box.right  <= n_right;
                    r_box.top    <= n_top;
                    r_box.bottom <= n_bottom;
                    r_cx         <= n_cx;
                    r_cy         <= n_cy;
                    r_state      <= more ? ST_G_START : ST_FINISH;
                end
                ST_FINISH: begin
                    // The result waits here until the output register is free.
                    if (out_free) begin
                        r_out_valid  <= 1'b1;
                        r_shift_x    <= n_shift_x;
                        r_shift_y    <= n_shift_y;
                        r_out_left   <= OUT_W'($signed((CRD_W+1)'(r_bl)) + (CRD_W+1)'(n_shift_x));
                        r_out_right  <= OUT_W'($signed((CRD_W+1)'(r_br)) + (CRD_W+1)'(n_shift_x));
                        r_out_top    <= OUT_W'($signed((CRD_W+1)'(r_bt)) + (CRD_W+1)'(n_shift_y));
                        r_out_bottom <= OUT_W'($signed((CRD_W+1)'(r_bb)) + (CRD_W+1)'(n_shift_y));
                        r_out_steps  <= r_steps;
                        r_out_empty  <= r_empty;
                        r_state      <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign o_res.valid        = r_out_valid;
    assign o_res.out_left     = r_out_left;
    assign o_res.out_top      = r_out_top;
    assign o_res.out_right    = r_out_right;
    assign o_res.out_bottom   = r_out_bottom;
    assign o_res.shift_x      = r_shift_x;
    assign o_res.shift_y      = r_shift_y;
    assign o_res.steps_used   = r_out_steps;
    assign o_res.empty_window = r_out_empty;

    a_run_leaves_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && (i_in.operation == OP_RUN)) |=> (r_state != ST_IDLE))
        else $error("run word accepted but search did not start");

    a_gather_done_expected: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        g_rsp.done |-> (r_state == ST_G_WAIT))
        else $error("window sum finished outside of a wait");

    a_div_done_expected: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_done |-> ((r_state == ST_DX_WAIT) || (r_state == ST_DY_WAIT)))
        else $error("divider finished outside of a wait");

    a_result_from_finish: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> ($past(r_state) == ST_FINISH))
        else $error("result word appeared without a finished search");

endmodule

// ===== tb/mean_shift_window_centroid_chk.sv =====
`timescale 1ns / 1ps
module mean_shift_window_centroid_chk
    import msw_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    msw_in_if    i_in,
    msw_res_if   i_res,
    msw_cfg_if   i_cfg,
    output int   o_errors,
    output int   o_pending
);

    localparam int FRAME_W   = 128;
    localparam int FRAME_H   = 128;
    localparam int SHOWN_MAX = 200;

    typedef struct {
        logic signed [8:0] left;
        logic signed [8:0] top;
        logic signed [8:0] right;
        logic signed [8:0] bottom;
        logic signed [6:0] shift_x;
        logic signed [6:0] shift_y;
        logic [3:0]        steps;
        logic              empty;
    } t_placed_box;

    logic [7:0]  weight_map [FRAME_W*FRAME_H];
    logic [7:0]  img_width;
    logic [7:0]  img_height;
    logic [5:0]  shift_cap;
    logic [3:0]  iter_cap;
    t_placed_box boxes_due [$];

    // Floor division; the divisor is always positive here.
    function automatic longint floor_quot(input longint n, input longint d);
        longint q;
        q = n / d;
        if (n % d != 0 && n < 0) q--;
        return q;
    endfunction

    function automatic longint clamp(input longint v, input longint lo, input longint hi);
        if (v < lo) return lo;
        if (v > hi) return hi;
        return v;
    endfunction

    // Runs the whole mean-shift search on the current frame and settings and
    // returns the box that the block must emit.
    function automatic t_placed_box place_window(input logic [7:0] bl, input logic [7:0] bt,
                                                 input logic [7:0] br, input logic [7:0] bb);
        longint left, top, right, bottom, cx, cy, cx0, cy0;
        longint mx, my, ws, dx, dy, lim, row, col, w;
        longint c_lo, c_hi, r_lo, r_hi, x_edge, y_edge;
        int steps;
        bit empty;
        t_placed_box res;
        left   = bl;
        top    = bt;
        right  = br;
        bottom = bb;
        x_edge = img_width;
        y_edge = img_height;
        cx0    = (left + right) / 2;
        cy0    = (top + bottom) / 2;
        cx     = cx0;
        cy     = cy0;
        dx     = 1;
        dy     = 1;
        steps  = 0;
        empty  = 0;
        while ((dx != 0 || dy != 0) && steps < int'(iter_cap) && !empty) begin
            // The scan is clipped to the stored frame, not to the set image size.
            c_lo = (left < 0) ? 0 : left;
            r_lo = (top < 0) ? 0 : top;
            c_hi = (right > FRAME_W) ? FRAME_W : right;
            r_hi = (bottom > FRAME_H) ? FRAME_H : bottom;
            mx = 0;
            my = 0;
            ws = 0;
            for (row = r_lo; row < r_hi; row++) begin
                for (col = c_lo; col < c_hi; col++) begin
                    w = weight_map[row*FRAME_W + col];
                    mx += w * (col - cx);
                    my += w * (row - cy);
                    ws += w;
                end
            end
            steps++;
            if (ws == 0) begin
                empty = 1;
            end else begin
                dx     = floor_quot(2*mx + ws, 2*ws);
                dy     = floor_quot(2*my + ws, 2*ws);
                left   = (left + dx < 0) ? 0 : left + dx;
                right  = (right + dx > x_edge) ? x_edge : right + dx;
                top    = (top + dy < 0) ? 0 : top + dy;
                bottom = (bottom + dy > y_edge) ? y_edge : bottom + dy;
                cx     = (left + right) / 2;
                cy     = (top + bottom) / 2;
            end
        end
        lim = shift_cap;
        dx  = clamp(cx - cx0, -lim, lim);
        dy  = clamp(cy - cy0, -lim, lim);
        res.left    = 9'(longint'(bl) + dx);
        res.top     = 9'(longint'(bt) + dy);
        res.right   = 9'(longint'(br) + dx);
        res.bottom  = 9'(longint'(bb) + dy);
        res.shift_x = 7'(dx);
        res.shift_y = 7'(dy);
        res.steps   = 4'(steps);
        res.empty   = empty;
        return res;
    endfunction

    task automatic flag_error(input string what, input longint got, input longint want);
        o_errors++;
        if (o_errors <= SHOWN_MAX)
            $display("%0t msw check: %s got %0d want %0d", $time, what, got, want);
    endtask

    task automatic check_result();
        t_placed_box want;
        if (boxes_due.size() == 0) begin
            flag_error("result word with no search pending", 0, 0);
        end else begin
            want = boxes_due.pop_front();
            if (i_res.out_left !== want.left)
                flag_error("out_left", i_res.out_left, want.left);
            if (i_res.out_top !== want.top)
                flag_error("out_top", i_res.out_top, want.top);
            if (i_res.out_right !== want.right)
                flag_error("out_right", i_res.out_right, want.right);
            if (i_res.out_bottom !== want.bottom)
                flag_error("out_bottom", i_res.out_bottom, want.bottom);
            if (i_res.shift_x !== want.shift_x)
                flag_error("shift_x", i_res.shift_x, want.shift_x);
            if (i_res.shift_y !== want.shift_y)
                flag_error("shift_y", i_res.shift_y, want.shift_y);
            if (i_res.steps_used !== want.steps)
                flag_error("steps_used", i_res.steps_used, want.steps);
            if (i_res.empty_window !== want.empty)
                flag_error("empty_window", i_res.empty_window, want.empty);
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            img_width  = 8'd128;
            img_height = 8'd128;
            shift_cap  = 6'd15;
            iter_cap   = 4'd10;
            boxes_due.delete();
        end else begin
            if (i_cfg.valid && i_cfg.ready) begin
                case (t_cfg_idx'(i_cfg.index))
                    CFG_IMAGE_WIDTH:  img_width  = i_cfg.data;
                    CFG_IMAGE_HEIGHT: img_height = i_cfg.data;
                    CFG_SHIFT_LIMIT:  shift_cap  = i_cfg.data[5:0];
                    CFG_MAX_ITER:     iter_cap   = i_cfg.data[3:0];
                    default: ;
                endcase
            end
            if (i_res.valid && i_res.ready) check_result();
            if (i_in.valid && i_in.ready) begin
                if (i_in.operation == OP_LOAD) begin
                    weight_map[{i_in.pixel_y, i_in.pixel_x}] = i_in.weight;
                end else begin
                    boxes_due.push_back(place_window(i_in.box_left, i_in.box_top,
                                                     i_in.box_right, i_in.box_bottom));
                end
            end
        end
        o_pending = boxes_due.size();
    end

endmodule

// ===== tb/mean_shift_window_centroid_tb.sv =====
`timescale 1ns / 1ps
module mean_shift_window_centroid_tb;
    import msw_pkg::*;

    localparam int CYCLE_LIMIT = 8_000_000;
    localparam int LONG_HOLD   = 400;
    localparam int DRAIN_WAIT  = 24;
    localparam int PHASE_ITEMS = 150;
    localparam int FRAME_SIDE  = 128;

    logic i_clk;
    logic i_rst_n;
    int   chk_errors;
    int   chk_pending;
    int   burst_left;
    int   hold_requests;
    int   holds_done;
    int   watch_cycles;

    msw_in_if  in_ch ();
    msw_res_if res_ch ();
    msw_cfg_if cfg_ch ();

    mean_shift_window_centroid i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_res   (res_ch),
        .i_cfg   (cfg_ch)
    );

    mean_shift_window_centroid_chk i_chk (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in      (in_ch),
        .i_res     (res_ch),
        .i_cfg     (cfg_ch),
        .o_errors  (chk_errors),
        .o_pending (chk_pending)
    );

    initial i_clk = 1'b0;
    always #6 i_clk = ~i_clk;

    function automatic int random_weight();
        case ($urandom_range(0, 9))
            0, 1, 2: return 0;
            3:       return 255;
            default: return $urandom_range(0, 255);
        endcase
    endfunction

    // Boxes hug the frame edges now and then, and sometimes start at 128.
    function automatic int pick_edge(input int extent);
        case ($urandom_range(0, 9))
            0:       return 0;
            1:       return FRAME_SIDE - extent;
            2:       return FRAME_SIDE;
            default: return $urandom_range(0, FRAME_SIDE - extent);
        endcase
    endfunction

    task automatic pace_sender();
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 48);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
            if (gap != 0) begin
                in_ch.valid <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
        end
        burst_left--;
    endtask

    task automatic offer_word(input logic op, input logic [6:0] px, input logic [6:0] py,
                              input logic [7:0] w, input logic [7:0] bl, input logic [7:0] bt,
                              input logic [7:0] br, input logic [7:0] bb);
        pace_sender();
        in_ch.valid      <= 1'b1;
        in_ch.operation  <= op;
        in_ch.pixel_x    <= px;
        in_ch.pixel_y    <= py;
        in_ch.weight     <= w;
        in_ch.box_left   <= bl;
        in_ch.box_top    <= bt;
        in_ch.box_right  <= br;
        in_ch.box_bottom <= bb;
        do @(posedge i_clk); while (!in_ch.ready);
        @(negedge i_clk);
    endtask

    // The unused fields of each word carry random values that the block must ignore.
    task automatic load_pixel(input int x, input int y, input int w);
        offer_word(OP_LOAD, 7'(x), 7'(y), 8'(w),
                   8'($urandom_range(0, 128)), 8'($urandom_range(0, 128)),
                   8'($urandom_range(0, 128)), 8'($urandom_range(0, 128)));
    endtask

    task automatic run_search(input int bl, input int bt, input int br, input int bb);
        offer_word(OP_RUN, 7'($urandom), 7'($urandom), 8'($urandom),
                   8'(bl), 8'(bt), 8'(br), 8'(bb));
    endtask

    // Most boxes are small so that searches stay short.
    task automatic run_random_box();
        int span, bw, bh, bl, bt, br, bb;
        span = ($urandom_range(0, 99) < 8) ? 40 : 12;
        bw = $urandom_range(0, span);
        bh = $urandom_range(0, span);
        bl = pick_edge(bw);
        bt = pick_edge(bh);
        br = (bl + bw > FRAME_SIDE) ? FRAME_SIDE : bl + bw;
        bb = (bt + bh > FRAME_SIDE) ? FRAME_SIDE : bt + bh;
        if ($urandom_range(0, 19) == 0) br = $urandom_range(0, bl);
        if ($urandom_range(0, 19) == 0) bb = $urandom_range(0, bt);
        run_search(bl, bt, br, bb);
    endtask

    task automatic random_items(input int count);
        for (int n = 0; n < count; n++) begin
            if ($urandom_range(0, 99) < 14)
                run_random_box();
            else
                load_pixel($urandom_range(0, 127), $urandom_range(0, 127), random_weight());
        end
    endtask

    task automatic write_reg(input t_cfg_idx idx, input int val);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= 8'(val);
        do @(posedge i_clk); while (!cfg_ch.ready);
        @(negedge i_clk);
    endtask

    task automatic configure(input int width, input int height, input int lim, input int iters);
        write_reg(CFG_IMAGE_WIDTH, width);
        write_reg(CFG_IMAGE_HEIGHT, height);
        write_reg(CFG_SHIFT_LIMIT, lim);
        write_reg(CFG_MAX_ITER, iters);
        cfg_ch.valid <= 1'b0;
        @(negedge i_clk);
    endtask

    // Loads produce no result word, so this waits until every search has been checked.
    task automatic drain();
        in_ch.valid <= 1'b0;
        while (chk_pending != 0) @(negedge i_clk);
        repeat (DRAIN_WAIT) @(negedge i_clk);
        burst_left = 0;
    endtask

    initial begin : result_sink
        int   span;
        logic level;
        res_ch.ready = 1'b0;
        @(negedge i_clk);
        forever begin
            if (holds_done < hold_requests) begin
                holds_done++;
                res_ch.ready <= 1'b0;
                span = LONG_HOLD;
            end else begin
                case ($urandom_range(0, 5))
                    0, 1: begin
                        level = 1'b0;
                        span  = $urandom_range(1, 6);
                    end
                    2: begin
                        level = 1'b1;
                        span  = $urandom_range(20, 80);
                    end
                    default: begin
                        level = 1'b1;
                        span  = $urandom_range(1, 10);
                    end
                endcase
                res_ch.ready <= level;
            end
            repeat (span) @(negedge i_clk);
        end
    end

    initial begin : watchdog
        for (watch_cycles = 0; watch_cycles < CYCLE_LIMIT; watch_cycles++)
            @(posedge i_clk);
        $display("mean_shift_window_centroid_tb: errors");
        $finish;
    end

    initial begin
        in_ch.valid      = 1'b0;
        in_ch.operation  = OP_LOAD;
        in_ch.pixel_x    = '0;
        in_ch.pixel_y    = '0;
        in_ch.weight     = '0;
        in_ch.box_left   = '0;
        in_ch.box_top    = '0;
        in_ch.box_right  = '0;
        in_ch.box_bottom = '0;
        cfg_ch.valid     = 1'b0;
        cfg_ch.index     = CFG_IMAGE_WIDTH;
        cfg_ch.data      = '0;
        i_rst_n          = 1'b0;
        burst_left       = 0;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Every pixel is written before any search may read it. A blank patch
        // near the lower right gives a window with no weight at all.
        for (int y = 0; y < FRAME_SIDE; y++) begin
            for (int x = 0; x < FRAME_SIDE; x++) begin
                if (x >= 96 && x < 112 && y >= 96 && y < 112)
                    load_pixel(x, y, 0);
                else
                    load_pixel(x, y, random_weight());
            end
        end

        // Reset settings.
        run_search(0, 0, 128, 128);
        run_search(128, 128, 128, 128);
        run_search(100, 20, 40, 60);
        run_search(20, 100, 60, 40);
        run_search(98, 98, 108, 108);
        load_pixel(127, 127, 255);
        load_pixel(0, 0, 255);
        load_pixel(127, 0, 0);
        run_search(120, 120, 128, 128);
        run_search(0, 0, 1, 1);
        run_search(127, 127, 128, 128);
        // A heavy corner inside the blank patch pulls the window hard.
        load_pixel(111, 111, 255);
        load_pixel(110, 111, 255);
        load_pixel(111, 110, 255);
        run_search(96, 96, 112, 112);
        run_search(0, 0, 8, 128);
        run_search(0, 120, 128, 128);
        run_search(5, 5, 6, 40);
        random_items(PHASE_ITEMS);
        drain();

        configure(128, 128, 63, 15);
        run_search(0, 0, 128, 128);
        random_items(PHASE_ITEMS);
        drain();

        configure(1, 1, 0, 1);
        run_search(0, 0, 128, 128);
        random_items(PHASE_ITEMS);
        drain();

        // Results are held back for a long stretch while words keep coming.
        configure(64, 100, 7, 3);
        hold_requests++;
        run_search(10, 10, 20, 20);
        random_items(PHASE_ITEMS);
        drain();

        configure(128, 1, 63, 0);
        random_items(PHASE_ITEMS);
        drain();

        configure($urandom_range(1, 128), $urandom_range(1, 128),
                  $urandom_range(0, 63), $urandom_range(1, 15));
        random_items(PHASE_ITEMS);
        drain();

        configure(1, 128, 31, 15);
        run_search(0, 0, 128, 128);
        random_items(PHASE_ITEMS);
        drain();

        if (chk_errors == 0 && chk_pending == 0)
            $display("mean_shift_window_centroid_tb: clean");
        else
            $display("mean_shift_window_centroid_tb: errors");
        $finish;
    end

endmodule
